// File: rtl/block_chain_free_list_allocator_top_defines.svh
// Assertion macros shared by the block chain free list allocator RTL.
// Included by the top module, which carries the concurrent assertions; they use clk and arst_n there.
`ifndef BLOCK_CHAIN_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define BLOCK_CHAIN_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCFL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCFL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bcfl_pkg.sv
// Types and codes of the block chain free list allocator.
// Used by bcfl_store and block_chain_free_list_allocator_top; depends on nothing.
`timescale 1ns / 1ps

package bcfl_pkg;

	localparam logic REQ_RESERVE = 1'b0;
	localparam logic REQ_FREE    = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOSPACE  = 2'd1,
		STAT_ZERO     = 2'd2,
		STAT_BADCHAIN = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RSV_RD,
		S_RSV_WR,
		S_FRE_RD,
		S_FRE_WR,
		S_RESP
	} fsm_t;

	typedef struct packed {
		logic        req_type;
		logic [12:0] block_count;
		logic [11:0] chain_start;
	} req_t;

	typedef struct packed {
		logic [11:0] head_block;
		status_t     status;
		logic [12:0] free_blocks_left;
		logic [12:0] blocks_handled;
	} rsp_t;

	// Commands from the sequencer to the block store.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_in_use;
		logic wr_touched;
	} store_cmd_t;

	// Status and read flags from the block store.
	typedef struct packed {
		logic busy;
		logic in_use;
		logic touched;
	} store_stat_t;

endpackage

// File: rtl/bcfl_store.sv
// Block store: one synchronous memory holding in-use bit, used-before bit and link.
// Runs a clearing sweep after reset and on request. Depends on bcfl_pkg.
`timescale 1ns / 1ps

module bcfl_store
	import bcfl_pkg::*;
#(
	parameter int unsigned NUM_BLOCKS = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear_start,
	input  store_cmd_t                          cmd,
	input  logic [$clog2(NUM_BLOCKS)-1:0]       rd_idx,
	input  logic [$clog2(NUM_BLOCKS)-1:0]       wr_idx,
	input  logic [$clog2(NUM_BLOCKS+1)-1:0]     wr_link,
	output store_stat_t                         stat,
	output logic [$clog2(NUM_BLOCKS+1)-1:0]     rd_link
);

	localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
	localparam int unsigned CW    = $clog2(NUM_BLOCKS + 1);
	localparam int unsigned ENT_W = CW + 2;

	logic [ENT_W-1:0] mem [NUM_BLOCKS];
	logic [ENT_W-1:0] rd_q;
	logic             busy_q;
	logic [IDX_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (clear_start) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == IDX_W'(NUM_BLOCKS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (cmd.wr_en) begin
			mem[wr_idx] <= {cmd.wr_in_use, cmd.wr_touched, wr_link};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	assign stat.busy    = busy_q;
	assign stat.in_use  = rd_q[ENT_W-1];
	assign stat.touched = rd_q[ENT_W-2];
	assign rd_link      = rd_q[CW-1:0];

endmodule

// File: rtl/block_chain_free_list_allocator_top.sv
// Top level of the block chain free list allocator: request sequencer and free list.
// Depends on bcfl_pkg, bcfl_store and block_chain_free_list_allocator_top_defines.svh.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid/req_ready    req_t (req_type, block_count, chain_start)
//  rsp       out        rsp_valid/rsp_ready    rsp_t (head_block, status, free..., handled)
//  cfg       in         cfg_we (no wait)       cfg_wdata, blocks_in_use_range
//
//  A reserve or a free reads and writes back each block in turn; a refused
//  reserve goes straight to the response. A walk that stops on a bad block
//  ends either before reading it (outside the range, or a full range walked)
//  or after reading it (not in use). Each block is a read-modify-write of
//  the block store: it is read, and written back in the next cycle.
//  After reset and after every configuration write the store is swept clear;
//  no request transaction is accepted during the sweep.
//  A finished result waits in the output register; a new request is accepted
//  meanwhile, and the sequencer stalls only when it must deliver the next one.

`include "block_chain_free_list_allocator_top_defines.svh"

module block_chain_free_list_allocator_top
	import bcfl_pkg::*;
#(
	parameter int unsigned NUM_BLOCKS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
	// Counts, free head and links: wide enough to hold NUM_BLOCKS itself.
	localparam int unsigned CW    = $clog2(NUM_BLOCKS + 1);
	// Walk pointer: wide enough for both a link and an input chain start.
	localparam int unsigned BW    = (CW > 12) ? CW : 12;
	localparam int unsigned RESET_RANGE = (NUM_BLOCKS < 4096) ? NUM_BLOCKS : 4096;

	fsm_t        state_q, state_d;
	store_cmd_t  cmd;
	store_stat_t stat;

	logic [CW-1:0]    range_q;
	logic [CW-1:0]    free_head_q;
	logic [CW-1:0]    free_total_q;
	logic [CW-1:0]    handled_q;
	logic [12:0]      count_q;
	logic [BW-1:0]    blk_q;
	logic [CW-1:0]    head_out_q;
	status_t          status_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [IDX_W-1:0] rd_idx, wr_idx, rsv_idx;
	logic [CW-1:0]    wr_link, rd_link, new_head;
	logic [31:0]      cfg_ext, eff32;
	logic [CW-1:0]    eff_cfg;
	logic             req_fire, last_step, walk_stop, rsp_load;

	// Effective range of a written register value: zero acts as one, and
	// anything above the built capacity acts as the capacity.
	assign cfg_ext = 32'(cfg_wdata);
	assign eff32   = (cfg_ext == 32'd0) ? 32'd1 :
	                 (cfg_ext > NUM_BLOCKS) ? NUM_BLOCKS : cfg_ext;
	assign eff_cfg = CW'(eff32);

	assign req_ready = (state_q == S_IDLE) && !stat.busy;
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	// A free head that has run past the store is read at block zero; this only
	// happens when no block is left to reserve.
	assign rsv_idx   = (32'(free_head_q) < NUM_BLOCKS) ? free_head_q[IDX_W-1:0] : '0;
	// A block that was handed out before links on; a fresh one steps the head.
	assign new_head  = stat.touched ? rd_link : free_head_q + 1'b1;
	assign last_step = (32'(handled_q) + 32'd1) == 32'(count_q);
	// The walk ends with an error outside the range or after a full range of blocks.
	assign walk_stop = (blk_q >= BW'(range_q)) || (handled_q >= range_q);

	bcfl_store #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear_start (cfg_we),
		.cmd         (cmd),
		.rd_idx      (rd_idx),
		.wr_idx      (wr_idx),
		.wr_link     (wr_link),
		.stat        (stat),
		.rd_link     (rd_link)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd.rd_en      = 1'b0;
		cmd.wr_en      = 1'b0;
		cmd.wr_in_use  = 1'b0;
		cmd.wr_touched = 1'b0;
		rd_idx         = rsv_idx;
		wr_idx         = rsv_idx;
		wr_link        = '0;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.req_type == REQ_FREE) begin
						state_d = S_FRE_RD;
					end else if ((req.block_count == 13'd0) ||
					             (32'(req.block_count) > 32'(free_total_q))) begin
						state_d = S_RESP;
					end else begin
						state_d = S_RSV_RD;
					end
				end
			end
			S_RSV_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_RSV_WR;
			end
			S_RSV_WR: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_in_use  = 1'b1;
				cmd.wr_touched = 1'b1;
				wr_link        = last_step ? '0 : new_head;
				state_d        = last_step ? S_RESP : S_RSV_RD;
			end
			S_FRE_RD: begin
				rd_idx = blk_q[IDX_W-1:0];
				if (walk_stop) begin
					state_d = S_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_FRE_WR;
				end
			end
			S_FRE_WR: begin
				wr_idx = blk_q[IDX_W-1:0];
				if (!stat.in_use) begin
					state_d = S_RESP;
				end else begin
					cmd.wr_en      = 1'b1;
					cmd.wr_touched = stat.touched;
					wr_link        = free_head_q;
					state_d        = (rd_link == '0) ? S_RESP : S_FRE_RD;
				end
			end
			S_RESP: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q      <= CW'(RESET_RANGE);
			free_head_q  <= '0;
			free_total_q <= CW'(RESET_RANGE);
			handled_q    <= '0;
			count_q      <= '0;
			blk_q        <= '0;
			head_out_q   <= '0;
			status_q     <= STAT_OK;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			// The output register refills in the cycle it is emptied, if a result waits.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				// A new range formats the store.
				range_q      <= eff_cfg;
				free_head_q  <= '0;
				free_total_q <= eff_cfg;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (req_fire) begin
							handled_q  <= '0;
							count_q    <= req.block_count;
							blk_q      <= BW'(req.chain_start);
							head_out_q <= '0;
							status_q   <= STAT_OK;
							if (req.req_type == REQ_RESERVE) begin
								if (req.block_count == 13'd0) begin
									status_q <= STAT_ZERO;
								end else if (32'(req.block_count) > 32'(free_total_q)) begin
									status_q <= STAT_NOSPACE;
								end else begin
									head_out_q <= free_head_q;
								end
							end
						end
					end
					S_RSV_WR: begin
						free_head_q <= new_head;
						handled_q   <= handled_q + 1'b1;
						if (last_step) begin
							free_total_q <= free_total_q - CW'(count_q);
						end
					end
					S_FRE_RD: begin
						if (walk_stop) begin
							status_q <= STAT_BADCHAIN;
						end
					end
					S_FRE_WR: begin
						if (!stat.in_use) begin
							status_q <= STAT_BADCHAIN;
						end else begin
							free_head_q  <= CW'(blk_q);
							free_total_q <= free_total_q + 1'b1;
							handled_q    <= handled_q + 1'b1;
							blk_q        <= BW'(rd_link);
						end
					end
					S_RESP: begin
						if (rsp_load) begin
							rsp_q.head_block       <= 12'(head_out_q);
							rsp_q.status           <= status_q;
							rsp_q.free_blocks_left <= 13'(free_total_q);
							rsp_q.blocks_handled   <= 13'(handled_q);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Assertions.
	`BCFL_ASSERT_NOW(a_total_in_range, 1'b1, free_total_q <= range_q, "free count over range")
	`BCFL_ASSERT_NOW(a_no_access_in_clear, stat.busy, !cmd.rd_en && !cmd.wr_en, "access in sweep")
	`BCFL_ASSERT_NOW(a_rsv_count, state_q == S_RSV_WR, handled_q < CW'(count_q), "reserve overrun")
	`BCFL_ASSERT_NEXT(a_accept_moves, req_fire && !cfg_we, state_q != S_IDLE, "accept stalled")

endmodule

// File: test/tb_top.sv
// Self-checking testbench for block_chain_free_list_allocator_top.
// Depends on bcfl_pkg and the allocator RTL; runs directed and random chain traffic.
`timescale 1ns / 1ps

module tb_top;
	import bcfl_pkg::*;

	localparam int NUM_BLK = 4096;
	// Longest quiet stretch of a correct run: a store sweep, a full chain walk
	// and a long response hold-off, taken
	// several times over.
	localparam int QUIET_LIMIT = 40000;
	localparam int LONG_HOLD = 400;

	// Clock and the single reset at the start of the run.
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Every input of the block starts at a known value.
	logic        req_valid = 1'b0;
	req_t        req = '0;
	logic        req_ready;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic [12:0] cfg_wdata = '0;

	block_chain_free_list_allocator_top #(
		.NUM_BLOCKS(NUM_BLK)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the block store, the free list and the range register.
	// The predictor updates it once per accepted request transaction.
	logic        blk_in_use  [NUM_BLK];
	logic        blk_touched [NUM_BLK];
	logic [12:0] blk_link    [NUM_BLK];
	logic [12:0] list_head;
	logic [12:0] free_count;
	logic [12:0] range_reg;

	// Responses still owed by the block, oldest first, and the heads of chains
	// that the stimulus may hand back later.
	rsp_t        pending_rsps[$];
	logic [11:0] live_heads[$];

	// Knobs shared between the stimulus and the response sink.
	logic send_idle = 1'b1;
	logic recv_idle = 1'b1;
	int   hold_off_request = 0;

	// Run statistics.
	int mismatch_count = 0;
	int requests_sent = 0;
	int range_settings = 1;
	int reserves_done = 0;
	int frees_done = 0;
	int refusals = 0;
	int bad_walks = 0;
	int long_holds = 0;

	// One row of the directed table. Where typed is set, want holds a result read
	// straight off the behavior; otherwise the predictor supplies the result.
	typedef struct packed {
		logic typed;
		req_t rq;
		rsp_t want;
	} step_row_t;

	step_row_t dir_steps[$];

	function automatic step_row_t mk_row(input logic typed, input logic kind,
			input int cnt, input int start, input int head, input status_t st,
			input int left, input int done);
		step_row_t row;
		row.typed = typed;
		row.rq.req_type = kind;
		row.rq.block_count = cnt[12:0];
		row.rq.chain_start = start[11:0];
		row.want.head_block = head[11:0];
		row.want.status = st;
		row.want.free_blocks_left = left[12:0];
		row.want.blocks_handled = done[12:0];
		return row;
	endfunction

	// A range of zero behaves as one block; anything above the built size is clipped.
	function automatic logic [12:0] managed_blocks();
		if (range_reg == 13'd0)
			return 13'd1;
		if (range_reg > NUM_BLK)
			return 13'(NUM_BLK);
		return range_reg;
	endfunction

	// A register write reformats the whole store.
	function automatic void format_shadow();
		for (int i = 0; i < NUM_BLK; i++) begin
			blk_in_use[i] = 1'b0;
			blk_touched[i] = 1'b0;
			blk_link[i] = '0;
		end
		list_head = '0;
		free_count = managed_blocks();
	endfunction

	// Applies one request to the shadow store and returns the response it owes.
	function automatic rsp_t predict_allocation(input req_t rq);
		rsp_t        res;
		logic [12:0] rng;
		logic [12:0] cur;
		logic [12:0] nxt;
		logic [11:0] idx;
		logic        walking;

		res = '0;
		res.status = STAT_OK;
		rng = managed_blocks();
		if (rq.req_type == REQ_RESERVE) begin
			if (rq.block_count == 13'd0) begin
				res.status = STAT_ZERO;
			end else if (rq.block_count > free_count) begin
				res.status = STAT_NOSPACE;
			end else begin
				res.head_block = list_head[11:0];
				for (int i = 0; i < rq.block_count; i++) begin
					// The head may sit one past the last block; it is only used
					// while free blocks remain.
					idx = (list_head < NUM_BLK) ? list_head[11:0] : 12'd0;
					blk_in_use[idx] = 1'b1;
					if (blk_touched[idx])
						list_head = blk_link[idx];
					else
						list_head = list_head + 13'd1;
					blk_touched[idx] = 1'b1;
					blk_link[idx] = (i + 1 == rq.block_count) ? 13'd0 : list_head;
				end
				free_count = free_count - rq.block_count;
				res.blocks_handled = rq.block_count;
			end
		end else begin
			cur = {1'b0, rq.chain_start};
			walking = 1'b1;
			while (walking) begin
				if (cur >= rng || !blk_in_use[cur[11:0]]) begin
					res.status = STAT_BADCHAIN;
					walking = 1'b0;
				end else if (res.blocks_handled >= rng) begin
					res.status = STAT_BADCHAIN;
					walking = 1'b0;
				end else begin
					blk_in_use[cur[11:0]] = 1'b0;
					nxt = blk_link[cur[11:0]];
					blk_link[cur[11:0]] = list_head;
					list_head = cur;
					free_count = free_count + 13'd1;
					res.blocks_handled = res.blocks_handled + 13'd1;
					cur = nxt;
					if (cur == 13'd0)
						walking = 1'b0;
				end
			end
		end
		res.free_blocks_left = free_count;
		return res;
	endfunction

	// Offers one request transaction and waits for it to be accepted. Valid is
	// only lowered when an idle gap follows, so a back-to-back transaction keeps
	// valid high without a second assignment in the same time step.
	task automatic issue_request(input req_t rq, input logic typed, input rsp_t want);
		int   gap;
		rsp_t predicted;

		gap = send_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= rq;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);

		predicted = predict_allocation(rq);
		pending_rsps.push_back(typed ? want : predicted);
		requests_sent++;
		case (predicted.status)
			STAT_OK: begin
				if (rq.req_type == REQ_RESERVE) begin
					reserves_done++;
					live_heads.push_back(predicted.head_block);
				end else begin
					frees_done++;
				end
			end
			STAT_BADCHAIN: bad_walks++;
			default: refusals++;
		endcase
	endtask

	// The sender stops offering and waits for every owed response.
	task automatic drain_responses();
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
	endtask

	// Register write while the block is idle; the shadow store is reformatted too.
	task automatic set_block_range(input logic [12:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		range_reg = value;
		format_shadow();
		live_heads.delete();
		range_settings++;
	endtask

	// Random traffic: mostly reserves of short chains and frees of chains that
	// were handed out, so blocks cycle through the free list and get reused.
	// The rest is double frees, stray chain starts and odd counts.
	task automatic run_random_traffic(input int n);
		req_t        rq;
		int          pick;
		int          sub;
		int          slot;
		logic [12:0] rng;

		for (int k = 0; k < n; k++) begin
			rng = managed_blocks();
			pick = $urandom_range(0, 99);
			rq.block_count = 13'($urandom_range(0, 8191));
			rq.chain_start = 12'($urandom_range(0, 4095));
			if (pick < 45) begin
				rq.req_type = REQ_RESERVE;
				sub = $urandom_range(0, 99);
				if (sub < 70)
					rq.block_count = 13'($urandom_range(1, 8));
				else if (sub < 85)
					rq.block_count = 13'($urandom_range(1, 64));
				else if (sub < 90)
					rq.block_count = 13'd0;
			end else if (pick < 85 && live_heads.size() > 0) begin
				rq.req_type = REQ_FREE;
				slot = $urandom_range(0, live_heads.size() - 1);
				rq.chain_start = live_heads[slot];
				// Now and then the chain stays on the list, which later gives a
				// double free.
				if ($urandom_range(0, 4) != 0)
					live_heads.delete(slot);
			end else begin
				rq.req_type = REQ_FREE;
				if ($urandom_range(0, 1) == 0)
					rq.chain_start = 12'($urandom_range(0, rng - 1));
			end
			issue_request(rq, 1'b0, '0);
		end
	endtask

	// One phase: drain, write the range register, set the idle pattern and run.
	task automatic run_phase(input logic [12:0] value, input int n, input logic s_idle,
			input logic r_idle, input int hold);
		drain_responses();
		set_block_range(value);
		send_idle = s_idle;
		recv_idle = r_idle;
		hold_off_request = hold;
		run_random_traffic(n);
	endtask

	// Response sink: random ready gaps, an occasional long hold-off, and a check
	// of every accepted response transaction against the oldest expectation.
	initial begin : rsp_sink
		int   gap;
		rsp_t want;
		rsp_t got;

		@(posedge arst_n);
		forever begin
			if (hold_off_request > 0) begin
				gap = hold_off_request;
				hold_off_request = 0;
				long_holds++;
			end else begin
				gap = recv_idle ? $urandom_range(0, 19) : 0;
			end
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (rsp_valid !== 1'b1);

			got = rsp;
			if (pending_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Mismatch: response with nothing owed: head %0d status %0d left %0d handled %0d",
						got.head_block, got.status, got.free_blocks_left,
						got.blocks_handled);
			end else begin
				want = pending_rsps.pop_front();
				if (got.head_block !== want.head_block || got.status !== want.status ||
						got.free_blocks_left !== want.free_blocks_left ||
						got.blocks_handled !== want.blocks_handled) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected head %0d status %0d left %0d handled %0d, got head %0d status %0d left %0d handled %0d",
							want.head_block, want.status, want.free_blocks_left,
							want.blocks_handled, got.head_block, got.status,
							got.free_blocks_left, got.blocks_handled);
				end
			end
		end
	end

	// Watchdog: a long stretch with no transaction on either channel means a hang.
	initial begin : watchdog
		int quiet;

		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Main sequence.
	initial begin : stimulus
		range_reg = 13'd4096;
		format_shadow();

		// Reset is held low from the start; the block then sweeps its store before it
		// accepts the first request transaction.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table at the reset range of 4096 blocks. Zero counts, counts
		// past the free total, frees of blocks not in use, reuse of freed blocks,
		// a broken chain, taking every block so the head runs past the end, and
		// whole-store reserve and free walks.
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 0, 4095, 0, STAT_ZERO, 4096, 0));
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 8191, 0, 0, STAT_NOSPACE, 4096, 0));
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 4097, 2730, 0, STAT_NOSPACE, 4096, 0));
		dir_steps.push_back(mk_row(1, REQ_FREE, 8191, 0, 0, STAT_BADCHAIN, 4096, 0));
		dir_steps.push_back(mk_row(1, REQ_FREE, 0, 4095, 0, STAT_BADCHAIN, 4096, 0));
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 1, 0, 0, STAT_OK, 4095, 1));
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 3, 0, 1, STAT_OK, 4092, 3));
		dir_steps.push_back(mk_row(1, REQ_FREE, 0, 1, 0, STAT_OK, 4095, 3));
		dir_steps.push_back(mk_row(1, REQ_FREE, 0, 1, 0, STAT_BADCHAIN, 4095, 0));
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 2, 0, 3, STAT_OK, 4093, 2));
		dir_steps.push_back(mk_row(1, REQ_FREE, 0, 2, 0, STAT_OK, 4094, 1));
		// Block 3 still links to block 2, which is free again: the walk stops.
		dir_steps.push_back(mk_row(1, REQ_FREE, 0, 3, 0, STAT_BADCHAIN, 4095, 1));
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 4095, 0, 3, STAT_OK, 0, 4095));
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 1, 0, 0, STAT_NOSPACE, 0, 0));
		dir_steps.push_back(mk_row(1, REQ_FREE, 0, 0, 0, STAT_OK, 1, 1));
		// Block 0 links to the head that ran one past the last block.
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 1, 0, 0, STAT_OK, 0, 1));
		dir_steps.push_back(mk_row(1, REQ_FREE, 0, 3, 0, STAT_OK, 4095, 4095));
		dir_steps.push_back(mk_row(1, REQ_FREE, 0, 0, 0, STAT_OK, 4096, 1));
		dir_steps.push_back(mk_row(1, REQ_RESERVE, 4096, 0, 0, STAT_OK, 0, 4096));
		dir_steps.push_back(mk_row(0, REQ_FREE, 5461, 0, 0, STAT_OK, 0, 0));
		dir_steps.push_back(mk_row(0, REQ_RESERVE, 5, 2730, 0, STAT_OK, 0, 0));
		dir_steps.push_back(mk_row(0, REQ_FREE, 2730, 1365, 0, STAT_OK, 0, 0));
		dir_steps.push_back(mk_row(0, REQ_RESERVE, 2730, 1365, 0, STAT_OK, 0, 0));
		dir_steps.push_back(mk_row(0, REQ_FREE, 0, 5, 0, STAT_OK, 0, 0));

		foreach (dir_steps[i])
			issue_request(dir_steps[i].rq, dir_steps[i].typed, dir_steps[i].want);

		// Random phases over several range settings, the extremes among them.
		// A value of 8191 clips to the full store and 0 acts as a single block.
		run_phase(13'd8191, 100, 1'b1, 1'b1, 0);
		run_phase(13'd0, 40, 1'b0, 1'b1, 0);
		run_phase(13'd1, 40, 1'b1, 1'b0, 0);
		// The sink holds off for a long stretch while requests keep coming, so
		// the output register fills and the block stops taking requests.
		run_phase(13'd37, 120, 1'b0, 1'b1, LONG_HOLD);
		run_phase(13'd4096, 100, 1'b0, 1'b0, 0);
		run_phase(13'd300, 120, 1'b1, 1'b1, 0);
		run_phase(13'd4095, 110, 1'b1, 1'b0, 0);
		drain_responses();

		// Wait on so that a stray extra response would still be seen.
		repeat (20) @(posedge clk);

		$display("Covered %0d requests over %0d range settings: %0d reserves, %0d frees,",
			requests_sent, range_settings, reserves_done, frees_done);
		$display("%0d refused reserves, %0d walks stopped on a bad chain, %0d long hold-offs.",
			refusals, bad_walks, long_holds);
		if (mismatch_count == 0 && pending_rsps.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatch_count,
				pending_rsps.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: block_chain_free_list_allocator_top.f
+incdir+rtl
rtl/bcfl_pkg.sv
rtl/bcfl_store.sv
rtl/block_chain_free_list_allocator_top.sv
test/tb_top.sv
